### rtl/stcws_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the comment and whitespace stripper.
// Used by the top level and by its port checker. Depends on nothing else.
package stcws_pkg;

	localparam int MAX_LINE_CHARS_DEF = 2048;

	// Number of result slots that one input byte can fill.
	localparam int RES_SLOTS = 4;
	localparam int RES_CNT_W = 3;
	localparam int RES_IDX_W = 2;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef enum logic [3:0] {
		LEX_CODE  = 4'b0001,
		LEX_STR   = 4'b0010,
		LEX_LINE  = 4'b0100,
		LEX_BLOCK = 4'b1000
	} lex_mode_t;

	// Result bytes gathered while one input byte is processed.
	typedef struct packed {
		logic [RES_SLOTS-1:0][7:0] ch;
		logic [RES_CNT_W-1:0]      n;
	} res_list_t;

endpackage

### rtl/shader_text_comment_whitespace_stripper_top.sv
`timescale 1ns / 1ps
// The first result of a byte is registered and appears in the cycle after its input transfer.
// Throughput: one byte per cycle while each byte yields at most one result and the output is
// not stalled; a byte that yields more holds the input until the single result register has
// drained them, one result per cycle while m_tready is high. Up to four results per byte.
// Reset (arst_n low, asynchronous): lexer and line state return to code mode, no result held.
// Top level of the comment and whitespace stripper; uses stcws_pkg.
module shader_text_comment_whitespace_stripper_top #(
	parameter int MAX_LINE_CHARS = stcws_pkg::MAX_LINE_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic       s_tlast,   // final_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic [1:0] m_tuser,   // [0] char_valid, [1] stream_done
	output logic       m_tlast    // run_last
);

	localparam int LINE_CNT_W = $clog2(MAX_LINE_CHARS);
	localparam logic [LINE_CNT_W-1:0] LINE_KEEP = LINE_CNT_W'(MAX_LINE_CHARS - 1);

	typedef struct packed {
		logic                  has_content;
		logic                  space_pending;
		logic [LINE_CNT_W-1:0] raw_count;
	} line_t;

	typedef struct packed {
		line_t      line;
		logic [1:0] n;
		logic [7:0] c0;
		logic [7:0] c1;
	} shape_t;

	// Line shaping of one comment-free character: yields up to two bytes.
	function automatic shape_t shape(line_t ln, logic [7:0] c);
		shape_t r;
		r.line = ln;
		r.n    = 2'd0;
		r.c0   = stcws_pkg::CH_NUL;
		r.c1   = stcws_pkg::CH_NUL;
		if (c == stcws_pkg::CH_CR || c == stcws_pkg::CH_LF) begin
			if (ln.has_content) begin
				r.n  = 2'd1;
				r.c0 = stcws_pkg::CH_LF;
			end
			r.line.has_content   = 1'b0;
			r.line.space_pending = 1'b0;
			r.line.raw_count     = '0;
		end else if (ln.raw_count < LINE_KEEP) begin
			r.line.raw_count = ln.raw_count + 1'b1;
			if (c == stcws_pkg::CH_SPACE || c == stcws_pkg::CH_TAB) begin
				if (ln.has_content) begin
					r.line.space_pending = 1'b1;
				end
			end else begin
				if (ln.space_pending) begin
					r.n  = 2'd2;
					r.c0 = stcws_pkg::CH_SPACE;
					r.c1 = c;
				end else begin
					r.n  = 2'd1;
					r.c0 = c;
				end
				r.line.space_pending = 1'b0;
				r.line.has_content   = 1'b1;
			end
		end
		return r;
	endfunction

	// Appends up to two bytes to the result list; bytes beyond the last slot are lost.
	function automatic stcws_pkg::res_list_t push(stcws_pkg::res_list_t l, logic [1:0] n,
			logic [7:0] c0, logic [7:0] c1);
		stcws_pkg::res_list_t r;
		r = l;
		for (int i = 0; i < 2; i++) begin
			if (2'(i) < n && r.n < stcws_pkg::RES_CNT_W'(stcws_pkg::RES_SLOTS)) begin
				r.ch[r.n[stcws_pkg::RES_IDX_W-1:0]] = (i == 0) ? c0 : c1;
				r.n = r.n + 1'b1;
			end
		end
		return r;
	endfunction

	// Lexer and line state.
	stcws_pkg::lex_mode_t mode_q, mode_d;
	logic  quote_dq_q, quote_dq_d;
	logic  escape_q, escape_d;
	logic  slash_q, slash_d;
	logic  star_q, star_d;
	line_t line_q, line_d;

	// Result register.
	logic [stcws_pkg::RES_SLOTS-1:0][7:0] out_ch_q;
	logic [stcws_pkg::RES_CNT_W-1:0]      out_cnt_q;
	logic [stcws_pkg::RES_IDX_W-1:0]      out_idx_q;
	logic                                 out_busy_q;
	logic                                 out_fin_q;
	logic                                 out_empty_q;

	stcws_pkg::res_list_t lst;
	logic       in_xfer;
	logic       out_xfer;
	logic       out_last;
	logic       drain_last;
	logic       load;
	logic [7:0] c;

	assign c          = s_tdata;
	assign out_last   = ({1'b0, out_idx_q} + 1'b1) == out_cnt_q;
	assign out_xfer   = m_tvalid && m_tready;
	assign drain_last = out_xfer && out_last;
	assign s_tready   = !out_busy_q || drain_last;
	assign in_xfer    = s_tvalid && s_tready;
	assign load       = in_xfer && (lst.n != '0 || s_tlast);

	always_comb begin
		shape_t sr;
		logic   do_code;
		mode_d     = mode_q;
		quote_dq_d = quote_dq_q;
		escape_d   = escape_q;
		slash_d    = slash_q;
		star_d     = star_q;
		line_d     = line_q;
		lst        = '0;
		do_code    = 1'b0;
		sr         = '0;
		case (mode_q)
			stcws_pkg::LEX_STR: begin
				sr     = shape(line_d, c);
				line_d = sr.line;
				lst    = push(lst, sr.n, sr.c0, sr.c1);
				if (escape_q) begin
					escape_d = 1'b0;
				end else if (c == stcws_pkg::CH_BSLASH) begin
					escape_d = 1'b1;
				end else if (c == (quote_dq_q ? stcws_pkg::CH_DQUOTE : stcws_pkg::CH_SQUOTE)) begin
					mode_d = stcws_pkg::LEX_CODE;
				end
			end
			stcws_pkg::LEX_LINE: begin
				if (c == stcws_pkg::CH_CR || c == stcws_pkg::CH_LF) begin
					mode_d = stcws_pkg::LEX_CODE;
					sr     = shape(line_d, c);
					line_d = sr.line;
					lst    = push(lst, sr.n, sr.c0, sr.c1);
				end
			end
			stcws_pkg::LEX_BLOCK: begin
				if (star_q && c == stcws_pkg::CH_SLASH) begin
					mode_d = stcws_pkg::LEX_CODE;
					star_d = 1'b0;
				end else begin
					star_d = (c == stcws_pkg::CH_STAR);
				end
			end
			default: begin
				if (slash_q) begin
					slash_d = 1'b0;
					if (c == stcws_pkg::CH_SLASH) begin
						mode_d = stcws_pkg::LEX_LINE;
						sr     = shape(line_d, stcws_pkg::CH_LF);
						line_d = sr.line;
						lst    = push(lst, sr.n, sr.c0, sr.c1);
					end else if (c == stcws_pkg::CH_STAR) begin
						mode_d = stcws_pkg::LEX_BLOCK;
						star_d = 1'b0;
						sr     = shape(line_d, stcws_pkg::CH_SPACE);
						line_d = sr.line;
						lst    = push(lst, sr.n, sr.c0, sr.c1);
					end else begin
						// The held slash was plain text after all.
						sr      = shape(line_d, stcws_pkg::CH_SLASH);
						line_d  = sr.line;
						lst     = push(lst, sr.n, sr.c0, sr.c1);
						do_code = 1'b1;
					end
				end else begin
					do_code = 1'b1;
				end
				if (do_code) begin
					if (c == stcws_pkg::CH_SLASH) begin
						slash_d = 1'b1;
					end else begin
						if (c == stcws_pkg::CH_DQUOTE || c == stcws_pkg::CH_SQUOTE) begin
							mode_d     = stcws_pkg::LEX_STR;
							quote_dq_d = (c == stcws_pkg::CH_DQUOTE);
							escape_d   = 1'b0;
						end
						sr     = shape(line_d, c);
						line_d = sr.line;
						lst    = push(lst, sr.n, sr.c0, sr.c1);
					end
				end
			end
		endcase

		if (s_tlast) begin
			if (slash_d) begin
				sr     = shape(line_d, stcws_pkg::CH_SLASH);
				line_d = sr.line;
				lst    = push(lst, sr.n, sr.c0, sr.c1);
			end
			if (line_d.has_content) begin
				lst = push(lst, 2'd1, stcws_pkg::CH_LF, stcws_pkg::CH_NUL);
			end
			// The end of a stream closes everything that is open.
			mode_d     = stcws_pkg::LEX_CODE;
			quote_dq_d = 1'b0;
			escape_d   = 1'b0;
			slash_d    = 1'b0;
			star_d     = 1'b0;
			line_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= stcws_pkg::LEX_CODE;
			quote_dq_q <= 1'b0;
			escape_q   <= 1'b0;
			slash_q    <= 1'b0;
			star_q     <= 1'b0;
			line_q     <= '0;
		end else if (in_xfer) begin
			mode_q     <= mode_d;
			quote_dq_q <= quote_dq_d;
			escape_q   <= escape_d;
			slash_q    <= slash_d;
			star_q     <= star_d;
			line_q     <= line_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_busy_q  <= 1'b0;
			out_idx_q   <= '0;
			out_cnt_q   <= '0;
			out_fin_q   <= 1'b0;
			out_empty_q <= 1'b0;
		end else if (load) begin
			out_busy_q  <= 1'b1;
			out_idx_q   <= '0;
			out_fin_q   <= s_tlast;
			// A final byte with nothing to show still leaves one empty end marker.
			out_empty_q <= (lst.n == '0);
			out_cnt_q   <= (lst.n == '0) ? stcws_pkg::RES_CNT_W'(1) : lst.n;
		end else if (drain_last) begin
			out_busy_q <= 1'b0;
		end else if (out_xfer) begin
			out_idx_q <= out_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_ch_q <= lst.ch;
		end
	end

	assign m_tvalid   = out_busy_q;
	assign m_tdata    = out_empty_q ? stcws_pkg::CH_NUL : out_ch_q[out_idx_q];
	assign m_tlast    = out_last;
	assign m_tuser[0] = !out_empty_q;
	assign m_tuser[1] = out_last && out_fin_q;

endmodule

### rtl/stcws_checker.sv
`timescale 1ns / 1ps
// Port checker for the comment and whitespace stripper, bound to the top level.
// Uses stcws_pkg for character codes.
module stcws_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);

	// A result that is not taken stays on the bus unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// Further results of the same byte follow straight after a non-final transfer.
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("run of results broken off");

	// The end of a stream is always the last result of its byte.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("stream end not on last result");

	// A stream that ends with a byte to show ends with a line break.
	a_done_lf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] && m_tuser[0] |-> m_tdata == stcws_pkg::CH_LF)
		else $error("stream does not end in a line break");

	// An empty marker only ever closes a stream and carries a zero byte.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && m_tdata == stcws_pkg::CH_NUL)
		else $error("malformed empty end marker");

endmodule

bind shader_text_comment_whitespace_stripper_top stcws_checker u_stcws_checker (.*);
